// File: hdl/spiral_job_queue_top_assert.svh
// Assertion macros for the spiral job queue checker.
// No dependencies; included by the checker file.
`ifndef SPIRAL_JOB_QUEUE_TOP_ASSERT_SVH
`define SPIRAL_JOB_QUEUE_TOP_ASSERT_SVH

// same-cycle implication
`define SJQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spiral_job_queue: assertion failed");

// next-cycle implication
`define SJQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spiral_job_queue: assertion failed");

`endif

// File: hdl/sjq_pkg.sv
// Shared types and constants for the spiral job queue.
// No dependencies; imported by every module of the block except sjq_ram.
`default_nettype none

package sjq_pkg;

   localparam int LIMIT_W = 9;
   localparam int COUNT_W = 9;
   localparam int OUT_COORD_W = 16;

   localparam logic OP_PUMP = 1'b0;
   localparam logic OP_TAKE = 1'b1;

   localparam logic [1:0] HEAD_PX = 2'd0;
   localparam logic [1:0] HEAD_PZ = 2'd1;
   localparam logic [1:0] HEAD_NX = 2'd2;
   localparam logic [1:0] HEAD_NZ = 2'd3;

   typedef struct packed {
      logic               operation;
      logic [LIMIT_W-1:0] push_limit;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0]            pushed_count;
      logic                          job_valid;
      logic signed [OUT_COORD_W-1:0] job_x;
      logic signed [OUT_COORD_W-1:0] job_z;
      logic [COUNT_W-1:0]            jobs_waiting;
      logic [OUT_COORD_W-1:0]        ring_latest;
      logic                          cursor_exhausted;
   } rsp_type;

   typedef struct packed {
      logic start_pump;
      logic start_take;
      logic push;
      logic pop;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic can_push;
      logic queue_empty;
   } status_type;

endpackage

`default_nettype wire

// File: hdl/sjq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sjq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/sjq_ctrl.sv
// Sequencer for pump and take items.
// Depends on sjq_pkg; drives the datapath through cmd_type.
`default_nettype none

module sjq_ctrl
   import sjq_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_operation,
   output logic            req_stall,
   input  wire status_type status,
   input  wire logic       rsp_free,
   output cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_PUMP   = 4'b0010,
      ST_READ   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_operation == OP_TAKE) begin
                  cmd.start_take = 1'b1;
                  state_in       = status.queue_empty ? ST_FINISH : ST_READ;
               end else begin
                  cmd.start_pump = 1'b1;
                  state_in       = ST_PUMP;
               end
            end
         end
         ST_PUMP: begin
            if (status.can_push) begin
               cmd.push = 1'b1;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_READ: begin
            cmd.pop  = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/sjq_datapath.sv
// Spiral cursor, queue pointers, job store and result assembly.
// Depends on sjq_pkg and sjq_ram; commanded by sjq_ctrl.
`default_nettype none

module sjq_datapath
   import sjq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 256,
   parameter int COORD_BITS  = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd,
   input  wire req_type req_data,
   output status_type   status,
   output rsp_type      result
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam int CB = COORD_BITS;
   localparam int XW = (CB > OUT_COORD_W) ? CB : OUT_COORD_W;
   localparam int CW = (FW > COUNT_W) ? FW : COUNT_W;

   logic [CB-1:0] x_ff, x_in, z_ff, z_in;
   logic [1:0]    heading_ff, heading_in;
   logic [CB-1:0] leg_ff, leg_in, prog_ff, prog_in;
   logic          pair_ff, pair_in;
   logic [CB-1:0] ring_ff, ring_in;
   logic          live_ff, live_in;
   logic [AW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [LIMIT_W-1:0] limit_ff;
   logic [COUNT_W-1:0] pushed_ff;
   logic               got_job_ff;

   logic [CB-1:0]   ax, az;
   logic [CB:0]     prog_inc;
   logic            leg_end;
   logic [2*CB-1:0] rd_data;
   logic [XW-1:0]   jx_wide, jz_wide, ring_wide;
   logic [CW-1:0]   fill_wide;

   // ring of the coordinate about to be emitted
   assign ax       = x_ff[CB-1] ? CB'(~x_ff + 1'b1) : x_ff;
   assign az       = z_ff[CB-1] ? CB'(~z_ff + 1'b1) : z_ff;
   assign prog_inc = {1'b0, prog_ff} + 1'b1;
   assign leg_end  = (prog_inc == {1'b0, leg_ff});

   always_comb begin
      x_in       = x_ff;
      z_in       = z_ff;
      heading_in = heading_ff;
      leg_in     = leg_ff;
      prog_in    = prog_ff;
      pair_in    = pair_ff;
      ring_in    = ring_ff;
      live_in    = live_ff;
      if (cmd.push) begin
         ring_in = (ax > az) ? ax : az;
         unique case (heading_ff)
            HEAD_PX: x_in = x_ff + 1'b1;
            HEAD_PZ: z_in = z_ff + 1'b1;
            HEAD_NX: x_in = x_ff - 1'b1;
            HEAD_NZ: z_in = z_ff - 1'b1;
            default: x_in = x_ff;
         endcase
         if (leg_end) begin
            prog_in    = '0;
            heading_in = heading_ff + 1'b1;
            pair_in    = ~pair_ff;
            if (pair_ff) begin
               if (&leg_ff) begin
                  live_in = 1'b0;
               end else begin
                  leg_in = leg_ff + 1'b1;
               end
            end
         end else begin
            prog_in = prog_inc[CB-1:0];
         end
      end
   end

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (cmd.push) begin
         tail_in = (tail_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         fill_in = fill_ff + 1'b1;
      end else if (cmd.pop) begin
         head_in = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff       <= '0;
         z_ff       <= '0;
         heading_ff <= HEAD_PX;
         leg_ff     <= CB'(1);
         prog_ff    <= '0;
         pair_ff    <= 1'b0;
         ring_ff    <= '0;
         live_ff    <= 1'b1;
         head_ff    <= '0;
         tail_ff    <= '0;
         fill_ff    <= '0;
      end else begin
         x_ff       <= x_in;
         z_ff       <= z_in;
         heading_ff <= heading_in;
         leg_ff     <= leg_in;
         prog_ff    <= prog_in;
         pair_ff    <= pair_in;
         ring_ff    <= ring_in;
         live_ff    <= live_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         fill_ff    <= fill_in;
      end
   end

   // per-item registers
   always_ff @(posedge clock) begin
      if (cmd.start_pump || cmd.start_take) begin
         limit_ff   <= (cmd.start_pump) ? req_data.push_limit : '0;
         pushed_ff  <= '0;
         got_job_ff <= 1'b0;
      end else begin
         if (cmd.push) begin
            pushed_ff <= pushed_ff + 1'b1;
         end
         if (cmd.pop) begin
            got_job_ff <= 1'b1;
         end
      end
   end

   sjq_ram #(
      .WIDTH (2 * CB),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (tail_ff),
      .wr_data ({x_ff, z_ff}),
      .rd_en   (cmd.pop),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   assign status.can_push    = (pushed_ff < limit_ff) &&
                               (fill_ff != FW'(QUEUE_DEPTH)) && live_ff;
   assign status.queue_empty = (fill_ff == '0);

   assign jx_wide   = XW'(rd_data[2*CB-1:CB]);
   assign jz_wide   = XW'(rd_data[CB-1:0]);
   assign ring_wide = XW'(ring_ff);
   assign fill_wide = CW'(fill_ff);

   always_comb begin
      result.pushed_count     = pushed_ff;
      result.job_valid        = got_job_ff;
      result.job_x            = got_job_ff ? jx_wide[OUT_COORD_W-1:0] : '0;
      result.job_z            = got_job_ff ? jz_wide[OUT_COORD_W-1:0] : '0;
      result.jobs_waiting     = fill_wide[COUNT_W-1:0];
      result.ring_latest      = ring_wide[OUT_COORD_W-1:0];
      result.cursor_exhausted = ~live_ff;
   end

endmodule

`default_nettype wire

// File: hdl/spiral_job_queue_top.sv
// Top level of the spiral job queue: sequencer, datapath, result register.
// Depends on sjq_pkg, sjq_ctrl, sjq_datapath.
//
//   channel  direction  handshake          beat
//   req      in         req_valid/stall    req_type (operation, push_limit)
//   rsp      out        rsp_valid/stall    rsp_type (one per req beat)
//
// Pump: N coordinates are pushed, one per cycle through the store's write port.
// Take: a job comes back through the registered store read; an empty queue skips that read.
// Reset clears cursor and queue pointers; the job store is not cleared.
// A new req beat is taken while the previous result still waits in the rsp register;
// a stalled rsp holds the sequencer only at the point where its result is ready.
`default_nettype none

module spiral_job_queue_top
   import sjq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 256,
   parameter int COORD_BITS  = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   cmd_type    cmd;
   status_type status;
   rsp_type    result;
   logic       rsp_free;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   assign rsp_free = ~rsp_valid_ff | ~rsp_stall;

   sjq_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_data.operation),
      .req_stall     (req_stall),
      .status        (status),
      .rsp_free      (rsp_free),
      .cmd           (cmd)
   );

   sjq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .COORD_BITS  (COORD_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .status   (status),
      .result   (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: hdl/sjq_checker.sv
// Port-level checks for spiral_job_queue_top, attached by bind.
// Depends on sjq_pkg and spiral_job_queue_top_assert.svh.
`default_nettype none

`include "spiral_job_queue_top_assert.svh"

module sjq_port_checker
   import sjq_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   `SJQ_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall,
      req_valid && $stable(req_data))

   `SJQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data))

   `SJQ_ASSERT_NOW(a_take_no_push, clock, reset, rsp_valid && rsp_data.job_valid,
      rsp_data.pushed_count == '0)

   `SJQ_ASSERT_NOW(a_no_job_zero, clock, reset, rsp_valid && !rsp_data.job_valid,
      rsp_data.job_x == '0 && rsp_data.job_z == '0)

   `SJQ_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)

endmodule

bind spiral_job_queue_top sjq_port_checker u_checker (.*);

`default_nettype wire
